@@ hdl/max_unpool_scatter_assert.svh @@
// ----------------------------------------------------------------------------
// Max unpool scatter assertion macros
// Concurrent assertion macros used by the max unpool scatter top module.
// ----------------------------------------------------------------------------
`ifndef MAX_UNPOOL_SCATTER_ASSERT_SVH
`define MAX_UNPOOL_SCATTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MUS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max_unpool_scatter: same-cycle check failed");

`define MUS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max_unpool_scatter: next-cycle check failed");

`else

`define MUS_ASSERT_IMPLIES(label, ante, cons)

`define MUS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/mus_pkg.sv @@
// ----------------------------------------------------------------------------
// Max unpool scatter package
// Sizes, command and register codes, and the structs shared by the modules.
// ----------------------------------------------------------------------------
package mus_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int EPOCH_W     = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int DIM_W       = 7;
  localparam int CHAN_CNT_W  = 9;
  localparam int PLANE_W     = 2 * DIM_W;
  localparam int MUL_W       = PLANE_W;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int FULL_W      = PROD_W + 1;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_SCATTER = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT   = 2'd3;

  localparam logic LAYOUT_CHANNEL_LAST = 1'b1;

  typedef struct packed {
    logic [PLANE_W-1:0]    plane;
    logic [CHAN_CNT_W-1:0] chan_count;
    logic                  layout;
  } cfg_t;

  typedef struct packed {
    logic                  rd;
    logic                  wr;
    logic                  clr;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] data;
  } store_req_t;

  typedef struct packed {
    logic busy;
    logic epoch_full;
  } store_stat_t;

endpackage

@@ hdl/mus_config.sv @@
// ----------------------------------------------------------------------------
// Max unpool scatter configuration
// Holds the shape registers and keeps the plane size up to date on each write.
// ----------------------------------------------------------------------------
module mus_config import mus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  logic [DIM_W-1:0]      out_height;
  logic [DIM_W-1:0]      out_width;
  logic [CHAN_CNT_W-1:0] channel_count;
  logic                  layout_mode;
  logic [PLANE_W-1:0]    plane;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_height    <= DIM_W'(1);
      out_width     <= DIM_W'(1);
      channel_count <= CHAN_CNT_W'(1);
      layout_mode   <= 1'b0;
      plane         <= PLANE_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEIGHT: begin
          out_height <= cfg_data[DIM_W-1:0];
          plane      <= PLANE_W'(cfg_data[DIM_W-1:0]) * PLANE_W'(out_width);
        end
        REG_WIDTH: begin
          out_width <= cfg_data[DIM_W-1:0];
          plane     <= PLANE_W'(out_height) * PLANE_W'(cfg_data[DIM_W-1:0]);
        end
        REG_CHANNELS: channel_count <= cfg_data[CHAN_CNT_W-1:0];
        REG_LAYOUT:   layout_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.plane      = plane;
  assign cfg.chan_count = channel_count;
  assign cfg.layout     = layout_mode;

endmodule

@@ hdl/mus_store.sv @@
// ----------------------------------------------------------------------------
// Max unpool scatter store
// Data memory plus an epoch tag memory; a clear advances the epoch, and a
// sweep rewrites every tag after reset and whenever the epoch wraps.
// ----------------------------------------------------------------------------
module mus_store import mus_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  store_req_t            req,
  output logic [DATA_WIDTH-1:0] rd_data,
  output logic                  rd_hit,
  output store_stat_t           stat
);

  logic [DATA_WIDTH-1:0] data_mem [STORE_DEPTH];
  logic [EPOCH_W-1:0]    tag_mem  [STORE_DEPTH];

  logic [EPOCH_W-1:0] epoch;
  logic               sweep_on;
  logic [ADDR_W-1:0]  sweep_idx;
  logic [EPOCH_W-1:0] rd_tag;
  logic [EPOCH_W-1:0] rd_epoch;
  logic               tag_we;
  logic [ADDR_W-1:0]  tag_addr;
  logic [EPOCH_W-1:0] tag_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= EPOCH_FIRST;
      sweep_on  <= 1'b1;
      sweep_idx <= '0;
    end else if (sweep_on) begin
      sweep_idx <= sweep_idx + ADDR_W'(1);
      if (sweep_idx == ADDR_W'(STORE_DEPTH - 1)) begin
        sweep_on <= 1'b0;
      end
    end else if (req.clr) begin
      if (epoch == EPOCH_LAST) begin
        epoch     <= EPOCH_FIRST;
        sweep_on  <= 1'b1;
        sweep_idx <= '0;
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end
  end

  always_comb begin
    tag_we    = sweep_on || req.wr;
    tag_addr  = sweep_on ? sweep_idx : req.addr;
    tag_wdata = sweep_on ? '0 : epoch;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_addr] <= tag_wdata;
    end
    if (req.wr) begin
      data_mem[req.addr] <= req.data;
    end
    if (req.rd) begin
      rd_data  <= data_mem[req.addr];
      rd_tag   <= tag_mem[req.addr];
      rd_epoch <= epoch;
    end
  end

  assign rd_hit          = (rd_tag == rd_epoch);
  assign stat.busy       = sweep_on;
  assign stat.epoch_full = (epoch == EPOCH_LAST);

endmodule

@@ hdl/max_unpool_scatter.sv @@
// ----------------------------------------------------------------------------
// Max unpool scatter
// Unpooled output store with clear, scatter and read commands.
// ----------------------------------------------------------------------------
// One command enters per cycle unless out_stall back-pressure or a tag sweep holds
// the input; its result then passes through the pipeline: one stage forms the
// address product, one adds, bounds-checks and accesses the memories, and one
// turns the registered read into the output register. Clear advances an 8-bit
// epoch that tags every entry; every 255th clear, and reset itself, start a sweep
// over the 4096-entry tag memory (one entry per cycle) during which no command is
// taken, while configuration writes still are.
`include "max_unpool_scatter_assert.svh"

module max_unpool_scatter import mus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [31:0]          elem_value,
  input  logic signed [31:0]   argmax_position,
  input  logic [7:0]           channel_number,
  input  logic [11:0]          read_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          read_data,
  output logic                 index_error
);

  cfg_t        cfg;
  store_req_t  st_req;
  store_stat_t st_stat;
  logic [DATA_WIDTH-1:0] st_rd_data;
  logic                  st_rd_hit;

  logic               in_acc;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [MUL_W-1:0]   addend;
  logic               pos_ok;

  logic                  s1_valid;
  logic [1:0]            s1_cmd;
  logic [DATA_WIDTH-1:0] s1_value;
  logic [PROD_W-1:0]     s1_prod;
  logic [MUL_W-1:0]      s1_addend;
  logic                  s1_pos_ok;
  logic [FULL_W-1:0]     addr_full;
  logic                  in_range;
  logic                  s1_adv;
  logic                  s1_free;
  logic                  sweep_pending;

  logic s2_valid;
  logic s2_rd;
  logic s2_err;
  logic s2_adv;
  logic s2_free;
  logic out_free;

  mus_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mus_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (st_req),
    .rd_data (st_rd_data),
    .rd_hit  (st_rd_hit),
    .stat    (st_stat)
  );

  assign out_free      = !out_valid || !out_stall;
  assign s2_adv        = s2_valid && out_free;
  assign s2_free       = !s2_valid || s2_adv;
  assign s1_adv        = s1_valid && s2_free;
  assign s1_free       = !s1_valid || s1_adv;
  assign sweep_pending = s1_valid && (s1_cmd == CMD_CLEAR) && st_stat.epoch_full;
  assign in_stall      = !s1_free || st_stat.busy || sweep_pending;
  assign in_acc        = in_valid && !in_stall;

  assign pos_ok = !argmax_position[31] && (argmax_position[30:0] < 31'(cfg.plane));

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    if (cmd == CMD_SCATTER) begin
      if (cfg.layout == LAYOUT_CHANNEL_LAST) begin
        mul_a  = argmax_position[MUL_W-1:0];
        mul_b  = MUL_W'(cfg.chan_count);
        addend = MUL_W'(channel_number);
      end else begin
        mul_a  = MUL_W'(channel_number);
        mul_b  = MUL_W'(cfg.plane);
        addend = argmax_position[MUL_W-1:0];
      end
    end else if (cmd == CMD_READ) begin
      addend = MUL_W'(read_address);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd    <= cmd;
      s1_value  <= DATA_WIDTH'(elem_value);
      s1_prod   <= PROD_W'(mul_a) * PROD_W'(mul_b);
      s1_addend <= addend;
      s1_pos_ok <= pos_ok;
    end
  end

  assign addr_full = FULL_W'(s1_prod) + FULL_W'(s1_addend);
  assign in_range  = addr_full < FULL_W'(STORE_DEPTH);

  always_comb begin
    st_req.rd   = s1_adv && (s1_cmd == CMD_READ) && in_range;
    st_req.wr   = s1_adv && (s1_cmd == CMD_SCATTER) && s1_pos_ok && in_range;
    st_req.clr  = s1_adv && (s1_cmd == CMD_CLEAR);
    st_req.addr = addr_full[ADDR_W-1:0];
    st_req.data = s1_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_rd  <= st_req.rd;
      s2_err <= (s1_cmd == CMD_SCATTER) && !(s1_pos_ok && in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      read_data   <= (s2_rd && st_rd_hit) ? 32'(st_rd_data) : 32'd0;
      index_error <= s2_err;
    end
  end

  `MUS_ASSERT_IMPLIES(a_sweep_blocks_input, st_stat.busy, in_stall)
  `MUS_ASSERT_IMPLIES(a_no_write_in_sweep, st_req.wr || st_req.rd, !st_stat.busy)
  `MUS_ASSERT_IMPLIES(a_error_has_no_data, out_valid && index_error, read_data == 32'd0)
  `MUS_ASSERT_NEXT(a_clear_wrap_sweeps, st_req.clr && st_stat.epoch_full, st_stat.busy)

endmodule
